/* sv/tnt_pkg.sv */
// Shared types and constants of the tree neighbor table.
package tnt_pkg;

    localparam int CHILD_SLOTS_DEF = 16;

    localparam logic [15:0] TIMEOUT_RESET = 16'd45;
    localparam logic [7:0]  RANK_NONE     = 8'hFF;

    localparam logic [1:0] MODE_BEACON = 2'd0;
    localparam logic [1:0] MODE_ALIVE  = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_REFRESH = 2'd1;
    localparam logic [1:0] EV_ADDED   = 2'd2;
    localparam logic [1:0] EV_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] sender;
        logic [7:0]  sender_rank;
        logic        sender_report_mode;
    } in_word_t;

    typedef struct packed {
        logic        parent_held;
        logic [15:0] parent_address;
        logic [7:0]  own_rank;
        logic        report_mode;
        logic [1:0]  child_event;
        logic [3:0]  child_slot;
        logic [4:0]  child_count;
    } out_word_t;

endpackage

/* sv/tree_neighbor_table.sv */
// Neighbor table of one node in a hop-count collection tree.
//
//  channel   direction  handshake              payload
//  item      in         start && !busy         in_word_t  (mode, sender, rank, report mode)
//  result    out        done, one cycle        out_word_t (parent, rank, child event/slot/count)
//  config    in         cfg_we                 cfg_wdata  (timeout_ticks)
//
// A beacon or an unused mode goes straight to the done state. An alive message or a
// tick walks every child slot through the one read port of the slot memories, then
// goes to the done state. done rises in the same cycle that busy falls. Reset clears
// the valid bits and the parent state and sets the timeout register to TIMEOUT_RESET
// at once; no clearing pass runs. The receiver cannot stall: done is a one-cycle strobe.
module tree_neighbor_table
    import tnt_pkg::*;
#(
    parameter int CHILD_SLOTS = CHILD_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        done,
    output out_word_t   result
);

    localparam int IW = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
    localparam int CW = $clog2(CHILD_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    in_word_t         item_reg;
    logic [15:0]      timeout_reg;
    logic [CHILD_SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    rd_cnt_reg, rd_cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IW-1:0]    chk_idx_reg, chk_idx_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    found_idx_reg, found_idx_next;
    logic             free_reg, free_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic             pvalid_reg, pvalid_next;
    logic [15:0]      parent_reg, parent_next;
    logic [7:0]       rank_reg, rank_next;
    logic [15:0]      ptimer_reg, ptimer_next;
    logic             rmode_reg, rmode_next;
    logic             done_reg, done_next;
    out_word_t        result_reg, result_next;

    // slot memories
    logic [15:0]      addr_mem [0:CHILD_SLOTS-1];
    logic [15:0]      timer_mem [0:CHILD_SLOTS-1];
    logic [15:0]      addr_rd, timer_rd;
    logic [IW-1:0]    rd_idx;
    logic             addr_we, timer_we;
    logic [IW-1:0]    addr_wa, timer_wa;
    logic [15:0]      timer_wd;

    logic             accept;
    logic [8:0]       rank_inc;

    assign accept   = start && (state_reg == S_IDLE);
    assign rd_idx   = rd_cnt_reg[IW-1:0];
    assign rank_inc = {1'b0, item_reg.sender_rank} + 9'd1;

    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_mem[addr_wa] <= item_reg.sender;
        end
        addr_rd <= addr_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (timer_we)
        begin
            timer_mem[timer_wa] <= timer_wd;
        end
        timer_rd <= timer_mem[rd_idx];
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        rd_cnt_next    = rd_cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        pvalid_next    = pvalid_reg;
        parent_next    = parent_reg;
        rank_next      = rank_reg;
        ptimer_next    = ptimer_reg;
        rmode_next     = rmode_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        addr_we        = 1'b0;
        addr_wa        = chk_idx_reg;
        timer_we       = 1'b0;
        timer_wa       = chk_idx_reg;
        timer_wd       = timeout_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_cnt_next = '0;
                    found_next  = 1'b0;
                    free_next   = 1'b0;
                    if (item.mode == MODE_ALIVE || item.mode == MODE_TICK)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_WALK:
            begin
                // issue one slot read a cycle
                if (rd_cnt_reg != CW'(CHILD_SLOTS))
                begin
                    rd_cnt_next  = rd_cnt_reg + CW'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx;
                end
                // examine the slot read in the previous cycle
                if (chk_vld_reg)
                begin
                    if (item_reg.mode == MODE_TICK)
                    begin
                        if (valid_reg[chk_idx_reg])
                        begin
                            timer_we = 1'b1;
                            if (timer_rd <= 16'd1)
                            begin
                                timer_wd                = '0;
                                valid_next[chk_idx_reg] = 1'b0;
                                count_next              = count_next - CW'(1);
                            end
                            else
                            begin
                                timer_wd = timer_rd - 16'd1;
                            end
                        end
                    end
                    else
                    begin
                        if (valid_reg[chk_idx_reg] && addr_rd == item_reg.sender && !found_reg)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = chk_idx_reg;
                        end
                        if (!valid_reg[chk_idx_reg] && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = chk_idx_reg;
                        end
                    end
                    if (chk_idx_reg == IW'(CHILD_SLOTS - 1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                result_next.child_event = EV_NONE;
                result_next.child_slot  = '0;
                case (item_reg.mode)
                    MODE_BEACON:
                    begin
                        if (item_reg.sender_rank < rank_reg)
                        begin
                            rmode_next = item_reg.sender_report_mode;
                        end
                        if (rank_inc < {1'b0, rank_reg})
                        begin
                            pvalid_next = 1'b1;
                            parent_next = item_reg.sender;
                            rank_next   = rank_inc[7:0];
                            ptimer_next = timeout_reg;
                        end
                        else if (pvalid_reg && parent_reg == item_reg.sender)
                        begin
                            ptimer_next = timeout_reg;
                        end
                    end
                    MODE_ALIVE:
                    begin
                        timer_wd = timeout_reg;
                        if (found_reg)
                        begin
                            timer_we                = 1'b1;
                            timer_wa                = found_idx_reg;
                            result_next.child_event = EV_REFRESH;
                            result_next.child_slot  = 4'(found_idx_reg);
                        end
                        else if (free_reg)
                        begin
                            timer_we                 = 1'b1;
                            timer_wa                 = free_idx_reg;
                            addr_we                  = 1'b1;
                            addr_wa                  = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            count_next               = count_reg + CW'(1);
                            result_next.child_event  = EV_ADDED;
                            result_next.child_slot   = 4'(free_idx_reg);
                        end
                        else
                        begin
                            result_next.child_event = EV_FULL;
                        end
                    end
                    MODE_TICK:
                    begin
                        if (pvalid_reg)
                        begin
                            if (ptimer_reg <= 16'd1)
                            begin
                                ptimer_next = '0;
                                pvalid_next = 1'b0;
                                parent_next = '0;
                                rank_next   = RANK_NONE;
                            end
                            else
                            begin
                                ptimer_next = ptimer_reg - 16'd1;
                            end
                        end
                    end
                    default:
                    begin
                        // unused mode: report state unchanged
                    end
                endcase
                result_next.parent_held    = pvalid_next;
                result_next.parent_address = parent_next;
                result_next.own_rank       = rank_next;
                result_next.report_mode    = rmode_next;
                result_next.child_count    = 5'(count_next);
                done_next                  = 1'b1;
                state_next                 = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            timeout_reg <= TIMEOUT_RESET;
            valid_reg   <= '0;
            count_reg   <= '0;
            rd_cnt_reg  <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            pvalid_reg  <= 1'b0;
            parent_reg  <= '0;
            rank_reg    <= RANK_NONE;
            ptimer_reg  <= '0;
            rmode_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            rd_cnt_reg  <= rd_cnt_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            free_reg    <= free_next;
            pvalid_reg  <= pvalid_next;
            parent_reg  <= parent_next;
            rank_reg    <= rank_next;
            ptimer_reg  <= ptimer_next;
            rmode_reg   <= rmode_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        chk_idx_reg   <= chk_idx_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* sv/tnt_checker.sv */
// Port-level checks of the tree neighbor table, bound to the top level.
module tnt_checker
    import tnt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_word_t result
);

    // an accepted word always raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // results never come back to back: each needs its own accepted word
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_no_parent: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.parent_held) |->
            (result.parent_address == 16'd0 && result.own_rank == RANK_NONE))
        else $error("parent fields set without a parent");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.child_event == EV_NONE || result.child_event == EV_FULL)) |->
            (result.child_slot == 4'd0))
        else $error("child slot reported without a slot event");

endmodule

bind tree_neighbor_table tnt_checker u_tnt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* tb/tree_neighbor_table_checker.sv */
// Checker for the tree neighbor table: tracks parent and child state and compares every result word.
module tree_neighbor_table_checker
    import tnt_pkg::*;
#(
    parameter int SLOTS = CHILD_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_word_t    item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        done,
    input  out_word_t   result,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] timeout_q;
    logic [15:0] kid_addr [SLOTS];
    logic        kid_live [SLOTS];
    logic [15:0] kid_tmr [SLOTS];
    logic [15:0] parent_addr;
    logic        parent_live;
    logic [7:0]  rank_q;
    logic [15:0] parent_tmr;
    logic        mode_q;
    out_word_t   status_fifo [$];

    function automatic logic [15:0] tick_down(input logic [15:0] t, output logic gone);
        gone = (t <= 16'd1);
        return gone ? 16'd0 : t - 16'd1;
    endfunction

    // Apply one word to the table and build the status word it should produce.
    task automatic apply_word(input in_word_t w, output out_word_t r);
        int          slot;
        int          cnt;
        logic        found;
        logic        gone;
        logic [1:0]  ev;
        logic [8:0]  rank_up;
        slot = 0;
        cnt = 0;
        found = 1'b0;
        ev = EV_NONE;
        rank_up = {1'b0, w.sender_rank} + 9'd1;
        case (w.mode)
            MODE_BEACON:
            begin
                if (w.sender_rank < rank_q)
                    mode_q = w.sender_report_mode;
                if (rank_up < {1'b0, rank_q})
                begin
                    parent_live = 1'b1;
                    parent_addr = w.sender;
                    rank_q = rank_up[7:0];
                    parent_tmr = timeout_q;
                end
                else if (parent_live && parent_addr == w.sender)
                begin
                    parent_tmr = timeout_q;
                end
            end
            MODE_ALIVE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && kid_live[i] && kid_addr[i] == w.sender)
                    begin
                        kid_tmr[i] = timeout_q;
                        ev = EV_REFRESH;
                        slot = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    ev = EV_FULL;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && !kid_live[i])
                        begin
                            kid_live[i] = 1'b1;
                            kid_addr[i] = w.sender;
                            kid_tmr[i] = timeout_q;
                            ev = EV_ADDED;
                            slot = i;
                            found = 1'b1;
                        end
                    end
                end
            end
            MODE_TICK:
            begin
                if (parent_live)
                begin
                    parent_tmr = tick_down(parent_tmr, gone);
                    if (gone)
                    begin
                        parent_live = 1'b0;
                        parent_addr = 16'd0;
                        rank_q = RANK_NONE;
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (kid_live[i])
                    begin
                        kid_tmr[i] = tick_down(kid_tmr[i], gone);
                        if (gone)
                            kid_live[i] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < SLOTS; i++)
            if (kid_live[i])
                cnt++;
        r.parent_held = parent_live;
        r.parent_address = parent_live ? parent_addr : 16'd0;
        r.own_rank = rank_q;
        r.report_mode = mode_q;
        r.child_event = ev;
        r.child_slot = slot[3:0];
        r.child_count = cnt[4:0];
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    task automatic compare_word(input out_word_t exp_w, input out_word_t got_w);
        check_field("parent_held", 16'(exp_w.parent_held), 16'(got_w.parent_held));
        check_field("parent_address", exp_w.parent_address, got_w.parent_address);
        check_field("own_rank", 16'(exp_w.own_rank), 16'(got_w.own_rank));
        check_field("report_mode", 16'(exp_w.report_mode), 16'(got_w.report_mode));
        check_field("child_event", 16'(exp_w.child_event), 16'(got_w.child_event));
        check_field("child_slot", 16'(exp_w.child_slot), 16'(got_w.child_slot));
        check_field("child_count", 16'(exp_w.child_count), 16'(got_w.child_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t w_exp;
        if (!rst_n)
        begin
            timeout_q = TIMEOUT_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                kid_addr[i] = 16'd0;
                kid_live[i] = 1'b0;
                kid_tmr[i] = 16'd0;
            end
            parent_addr = 16'd0;
            parent_live = 1'b0;
            rank_q = RANK_NONE;
            parent_tmr = 16'd0;
            mode_q = 1'b0;
            status_fifo.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (status_fifo.size() == 0)
                begin
                    $error("result word with none outstanding");
                    fail_count++;
                end
                else
                begin
                    compare_word(status_fifo.pop_front(), result);
                end
            end
            if (cfg_we)
                timeout_q = cfg_wdata;
            if (start && !busy)
            begin
                apply_word(item, w_exp);
                status_fifo.push_back(w_exp);
            end
            pending = status_fifo.size();
        end
    end

endmodule

/* tb/tree_neighbor_table_tb.sv */
// Top of the tree neighbor table testbench: clock, reset, stimulus and verdict.
module tree_neighbor_table_tb;
    import tnt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = CHILD_SLOTS_DEF + 8;
    localparam int PHASE_WORDS = 55;
    localparam int POOL_SIZE = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_word_t    item = '0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        done;
    out_word_t   result;
    int          fail_count;
    int          pending;
    int          cycles = 0;

    logic [15:0] neighbor_pool [POOL_SIZE];
    logic [15:0] timeout_plan [7];

    tree_neighbor_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    tree_neighbor_table_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic in_word_t word_of(input logic [1:0] m, input logic [15:0] addr,
                                         input logic [7:0] rank, input logic rmode);
        in_word_t w;
        w.mode = m;
        w.sender = addr;
        w.sender_rank = rank;
        w.sender_report_mode = rmode;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly addresses from a small neighbor set, so refreshes and a full table happen.
    function automatic in_word_t random_word();
        in_word_t w;
        int r;
        r = $urandom_range(0, 99);
        w.mode = (r < 30) ? MODE_BEACON : (r < 70) ? MODE_ALIVE :
                 (r < 95) ? MODE_TICK : MODE_UNUSED;
        w.sender = ($urandom_range(0, 99) < 85) ?
                   neighbor_pool[$urandom_range(0, POOL_SIZE - 1)] : 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 12)
            w.sender_rank = RANK_NONE;
        else if (r < 20)
            w.sender_rank = 8'd254;
        else if (r < 28)
            w.sender_rank = 8'd0;
        else if (r < 65)
            w.sender_rank = 8'($urandom_range(0, 12));
        else
            w.sender_rank = 8'($urandom);
        w.sender_report_mode = 1'($urandom);
        return w;
    endfunction

    // Hold start until the word is taken; drop it only when a gap follows.
    task automatic send_word(input in_word_t w, input int gap);
        item <= w;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        bit no_gaps;
        neighbor_pool[0] = 16'h0000;
        neighbor_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            neighbor_pool[i] = 16'($urandom);
        timeout_plan = '{16'd1, 16'd2, 16'd0, 16'hFFFF, 16'd6,
                         16'($urandom_range(3, 30)), TIMEOUT_RESET};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: beacon edge ranks, parent take-over and refresh, unused mode.
        send_word(word_of(MODE_BEACON, 16'hFFFF, RANK_NONE, 1'b1), 0);
        send_word(word_of(MODE_BEACON, 16'h1234, 8'd254, 1'b1), 1);
        send_word(word_of(MODE_BEACON, 16'hFFFF, 8'd0, 1'b0), 0);
        send_word(word_of(MODE_BEACON, 16'hFFFF, 8'd0, 1'b1), 2);
        send_word(word_of(MODE_UNUSED, 16'hFFFF, RANK_NONE, 1'b1), 0);
        // Fill every child slot, then overflow and refresh.
        for (int i = 0; i < CHILD_SLOTS_DEF; i++)
            send_word(word_of(MODE_ALIVE, 16'd1 << i, 8'd0, 1'b0), i % 3);
        send_word(word_of(MODE_ALIVE, 16'h0000, 8'd0, 1'b0), 0);
        send_word(word_of(MODE_ALIVE, 16'h8000, 8'd0, 1'b0), 0);
        send_word(word_of(MODE_TICK, 16'h0000, 8'd0, 1'b0), 0);
        drain();

        // Random phases, each under its own timeout, with the block idle at every write.
        foreach (timeout_plan[p])
        begin
            write_timeout(timeout_plan[p]);
            no_gaps = (p == 3);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_word(), no_gaps ? 0 : pick_gap());
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
